### hw/rtl/y86ex_pkg.sv
// Shared types, codes and helpers for the Y86 execute stage.
package y86ex_pkg;

  // Datapath width of the ALU; port fields stay 32 bits.
  localparam int DATA_W = 32;
  localparam int FIELD_W = 32;
  localparam int StepConst = 4;
  localparam logic [3:0] RegNone = 4'hF;

  typedef enum logic [1:0] {
    STAT_AOK = 2'd0,
    STAT_HLT = 2'd1,
    STAT_ADR = 2'd2,
    STAT_INS = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    I_HALT    = 4'd0,
    I_NOP     = 4'd1,
    I_REGMOVE = 4'd2,
    I_IMMMOVE = 4'd3,
    I_STORE   = 4'd4,
    I_LOAD    = 4'd5,
    I_OPL     = 4'd6,
    I_JXX     = 4'd7,
    I_CALL    = 4'd8,
    I_RET     = 4'd9,
    I_PUSHL   = 4'd10,
    I_POPL    = 4'd11,
    I_DUMP    = 4'd12
  } icode_t;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_AND = 4'd2,
    ALU_XOR = 4'd3
  } alu_fn_t;

  typedef enum logic [3:0] {
    C_ALWAYS = 4'd0,
    C_LE     = 4'd1,
    C_L      = 4'd2,
    C_E      = 4'd3,
    C_NE     = 4'd4,
    C_GE     = 4'd5,
    C_G      = 4'd6
  } cond_t;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
    logic enabled;
  } flag_state_t;

  localparam flag_state_t FlagsReset = '{zf: 1'b0, sf: 1'b0, of: 1'b0, enabled: 1'b1};

  typedef struct packed {
    logic [1:0]                stage_status;
    logic [3:0]                instr_code;
    logic [3:0]                instr_func;
    logic signed [FIELD_W-1:0] const_value;
    logic signed [FIELD_W-1:0] value_a;
    logic signed [FIELD_W-1:0] value_b;
    logic [3:0]                dest_e_in;
    logic [3:0]                dest_m_in;
    logic [1:0]                mem_stage_status;
    logic [1:0]                wb_stage_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                out_status;
    logic [3:0]                out_code;
    logic                      cond_true;
    logic signed [FIELD_W-1:0] exec_value;
    logic signed [FIELD_W-1:0] pass_value_a;
    logic [3:0]                dest_e_out;
    logic [3:0]                dest_m_out;
    logic                      bubble_memory;
  } out_item_t;

  // Sign-extend or truncate a port word to the datapath width.
  function automatic logic [DATA_W-1:0] to_dw(input logic signed [FIELD_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_W-1:0];
  endfunction

  // Zero-extend or truncate a datapath word back to the port width.
  function automatic logic [FIELD_W-1:0] from_dw(input logic [DATA_W-1:0] r);
    logic [63:0] z;
    z = 64'(r);
    return z[FIELD_W-1:0];
  endfunction

endpackage

### hw/rtl/y86ex_in_if.sv
// Input channel: one decoded instruction per item.
interface y86ex_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           stage_status;
  logic [3:0]                           instr_code;
  logic [3:0]                           instr_func;
  logic signed [y86ex_pkg::FIELD_W-1:0] const_value;
  logic signed [y86ex_pkg::FIELD_W-1:0] value_a;
  logic signed [y86ex_pkg::FIELD_W-1:0] value_b;
  logic [3:0]                           dest_e_in;
  logic [3:0]                           dest_m_in;
  logic [1:0]                           mem_stage_status;
  logic [1:0]                           wb_stage_status;

  modport source (
    output valid, stage_status, instr_code, instr_func, const_value, value_a, value_b,
           dest_e_in, dest_m_in, mem_stage_status, wb_stage_status,
    input  ready
  );
  modport sink (
    input  valid, stage_status, instr_code, instr_func, const_value, value_a, value_b,
           dest_e_in, dest_m_in, mem_stage_status, wb_stage_status,
    output ready
  );
endinterface

### hw/rtl/y86ex_out_if.sv
// Output channel: one execute result per item.
interface y86ex_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           out_status;
  logic [3:0]                           out_code;
  logic                                 cond_true;
  logic signed [y86ex_pkg::FIELD_W-1:0] exec_value;
  logic signed [y86ex_pkg::FIELD_W-1:0] pass_value_a;
  logic [3:0]                           dest_e_out;
  logic [3:0]                           dest_m_out;
  logic                                 bubble_memory;

  modport source (
    output valid, out_status, out_code, cond_true, exec_value, pass_value_a,
           dest_e_out, dest_m_out, bubble_memory,
    input  ready
  );
  modport sink (
    input  valid, out_status, out_code, cond_true, exec_value, pass_value_a,
           dest_e_out, dest_m_out, bubble_memory,
    output ready
  );
endinterface

### hw/rtl/y86_execute_stage_unit.sv
// Y86 execute stage: input register, execute logic, flag state, result register.
// Path: an accepted instruction is held in the input register, executed, and then
// held in the result register, from which its result can be taken.
// Throughput: one instruction per cycle while results are taken; the flags feed back.
// Stalls: while a result waits, the input register takes one more instruction,
// then the input holds off until the result is taken.
// Reset (synchronous, rst high): both stages empty, ZF/SF/OF cleared,
// flag updates enabled again.
module y86_execute_stage_unit (
  input  logic               clk,
  input  logic               rst,
  y86ex_in_if.sink           instr,
  y86ex_out_if.source        result
);

  // Input register
  y86ex_pkg::in_item_t    s1_item;
  logic                   s1_valid;

  // Result register
  y86ex_pkg::out_item_t   out_item;
  logic                   out_valid;

  // Condition codes and the exception freeze bit
  y86ex_pkg::flag_state_t flags;
  y86ex_pkg::flag_state_t flags_next;
  y86ex_pkg::out_item_t   res_next;

  logic advance;
  logic s1_fire;

  // Result register can take a new item when empty or being drained
  assign advance       = !out_valid || result.ready;
  assign s1_fire       = s1_valid && advance;
  assign instr.ready   = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_item.stage_status     <= instr.stage_status;
      s1_item.instr_code       <= instr.instr_code;
      s1_item.instr_func       <= instr.instr_func;
      s1_item.const_value      <= instr.const_value;
      s1_item.value_a          <= instr.value_a;
      s1_item.value_b          <= instr.value_b;
      s1_item.dest_e_in        <= instr.dest_e_in;
      s1_item.dest_m_in        <= instr.dest_m_in;
      s1_item.mem_stage_status <= instr.mem_stage_status;
      s1_item.wb_stage_status  <= instr.wb_stage_status;
    end
  end

  y86ex_alu u_alu (
    .item       (s1_item),
    .flags      (flags),
    .res        (res_next),
    .flags_next (flags_next)
  );

  // Flags commit only when the instruction moves on, so order is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= y86ex_pkg::FlagsReset;
    end else if (s1_fire) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.out_status    = out_item.out_status;
  assign result.out_code      = out_item.out_code;
  assign result.cond_true     = out_item.cond_true;
  assign result.exec_value    = out_item.exec_value;
  assign result.pass_value_a  = out_item.pass_value_a;
  assign result.dest_e_out    = out_item.dest_e_out;
  assign result.dest_m_out    = out_item.dest_m_out;
  assign result.bubble_memory = out_item.bubble_memory;

`ifndef SYNTHESIS
  // Once frozen, flag updates stay off until reset
  a_freeze_sticky: assert property (@(posedge clk) disable iff (rst)
    !flags.enabled |=> !flags.enabled)
    else $error("flag freeze released without reset");

  // Flags move only when an instruction leaves the input register
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(flags))
    else $error("flags changed with no instruction executing");

  // A not-taken cmov never writes a register
  a_cmov_dest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.bubble_memory && out_item.out_code == y86ex_pkg::I_REGMOVE &&
     !out_item.cond_true) |-> (out_item.dest_e_out == y86ex_pkg::RegNone))
    else $error("cmov not taken but destination kept");

  // A bubble carries a nop with no destinations
  a_bubble_nop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.bubble_memory) |->
      (out_item.out_code == y86ex_pkg::I_NOP && out_item.dest_e_out == y86ex_pkg::RegNone &&
       out_item.dest_m_out == y86ex_pkg::RegNone))
    else $error("bubble result is not a nop");
`endif

endmodule

### hw/rtl/y86ex_cond.sv
// Jump / cmov condition evaluation from the current flags.
module y86ex_cond (
  input  y86ex_pkg::flag_state_t flags,
  input  logic [3:0]             sel,
  output logic                   taken
);

  logic lt;

  assign lt = flags.sf ^ flags.of;

  always_comb begin
    case (sel)
      y86ex_pkg::C_ALWAYS: taken = 1'b1;
      y86ex_pkg::C_LE:     taken = lt | flags.zf;
      y86ex_pkg::C_L:      taken = lt;
      y86ex_pkg::C_E:      taken = flags.zf;
      y86ex_pkg::C_NE:     taken = ~flags.zf;
      y86ex_pkg::C_GE:     taken = ~lt;
      y86ex_pkg::C_G:      taken = ~lt & ~flags.zf;
      default:             taken = 1'b0;
    endcase
  end

endmodule

### hw/rtl/y86ex_alu.sv
// Execute logic: valE, condition, flag next state and bubble handling.
module y86ex_alu (
  input  y86ex_pkg::in_item_t    item,
  input  y86ex_pkg::flag_state_t flags,
  output y86ex_pkg::out_item_t   res,
  output y86ex_pkg::flag_state_t flags_next
);

  localparam int Msb = y86ex_pkg::DATA_W - 1;

  logic [Msb:0]           a;
  logic [Msb:0]           b;
  logic [Msb:0]           c;
  logic [Msb:0]           vale;
  logic [1:0]             stat;
  logic                   cond_eval;
  logic                   cnd;
  logic                   enabled;
  logic                   alu_ok;
  logic                   alu_of;
  logic                   bubble;
  logic [3:0]             dste;
  y86ex_pkg::flag_state_t nf;

  y86ex_cond u_cond (
    .flags (flags),
    .sel   (item.instr_func),
    .taken (cond_eval)
  );

  assign a = y86ex_pkg::to_dw(item.value_a);
  assign b = y86ex_pkg::to_dw(item.value_b);
  assign c = y86ex_pkg::to_dw(item.const_value);

  always_comb begin
    // any exception in this stage freezes flags from here on
    enabled    = flags.enabled & (item.stage_status == y86ex_pkg::STAT_AOK);
    nf         = flags;
    nf.enabled = enabled;
    stat       = item.stage_status;
    vale       = '0;
    cnd        = 1'b0;
    alu_ok     = 1'b1;
    alu_of     = 1'b0;

    if (item.stage_status != y86ex_pkg::STAT_INS) begin
      case (item.instr_code)
        y86ex_pkg::I_REGMOVE, y86ex_pkg::I_JXX: begin
          cnd  = cond_eval;
          vale = a;
        end
        y86ex_pkg::I_IMMMOVE, y86ex_pkg::I_DUMP: vale = c;
        y86ex_pkg::I_STORE, y86ex_pkg::I_LOAD: vale = c + b;
        y86ex_pkg::I_OPL: begin
          case (item.instr_func)
            y86ex_pkg::ALU_ADD: begin
              vale   = b + a;
              alu_of = (a[Msb] == b[Msb]) && (vale[Msb] != b[Msb]);
            end
            y86ex_pkg::ALU_SUB: begin
              vale   = b - a;
              alu_of = (a[Msb] != b[Msb]) && (vale[Msb] != b[Msb]);
            end
            y86ex_pkg::ALU_AND: vale = b & a;
            y86ex_pkg::ALU_XOR: vale = b ^ a;
            default: begin
              alu_ok = 1'b0;
              stat   = y86ex_pkg::STAT_INS;
              vale   = '0;
            end
          endcase
          if (enabled) begin
            if (alu_ok) begin
              nf.of = alu_of;
            end
            nf.zf = (vale == '0);
            nf.sf = vale[Msb];
          end
        end
        y86ex_pkg::I_CALL, y86ex_pkg::I_PUSHL: vale = b - y86ex_pkg::DATA_W'(y86ex_pkg::StepConst);
        y86ex_pkg::I_RET, y86ex_pkg::I_POPL:   vale = b + y86ex_pkg::DATA_W'(y86ex_pkg::StepConst);
        default: vale = '0;
      endcase
    end

    // cmov not taken: no register write
    dste = item.dest_e_in;
    if (item.instr_code == y86ex_pkg::I_REGMOVE && !cnd) begin
      dste = y86ex_pkg::RegNone;
    end

    bubble = (item.mem_stage_status != y86ex_pkg::STAT_AOK) ||
             (item.wb_stage_status != y86ex_pkg::STAT_AOK);

    if (bubble) begin
      if (enabled) begin
        nf.zf = 1'b0;
        nf.sf = 1'b0;
        nf.of = 1'b0;
      end
      res.out_status    = y86ex_pkg::STAT_AOK;
      res.out_code      = y86ex_pkg::I_NOP;
      res.cond_true     = 1'b0;
      res.exec_value    = '0;
      res.pass_value_a  = '0;
      res.dest_e_out    = y86ex_pkg::RegNone;
      res.dest_m_out    = y86ex_pkg::RegNone;
      res.bubble_memory = 1'b1;
    end else begin
      res.out_status    = stat;
      res.out_code      = item.instr_code;
      res.cond_true     = cnd;
      res.exec_value    = y86ex_pkg::from_dw(vale);
      res.pass_value_a  = item.value_a;
      res.dest_e_out    = dste;
      res.dest_m_out    = item.dest_m_in;
      res.bubble_memory = 1'b0;
    end

    flags_next = nf;
  end

endmodule

### verif/y86ex_exec_checker.sv
// Execute-stage checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 100ps

module y86ex_exec_checker
  import y86ex_pkg::*;
(
  input  logic clk,
  input  logic rst,
  y86ex_in_if  instr,
  y86ex_out_if result,
  output int   mismatches,
  output int   pending,
  output int   results_seen,
  output int   bubbles_seen,
  output int   taken_seen
);

  typedef logic [DATA_W-1:0] word_t;

  // Shadow condition codes and the freeze bit
  logic zf_f, sf_f, of_f, flags_on;

  out_item_t exec_results_q[$];

  function automatic logic cond_holds(logic [3:0] sel);
    logic lt;
    lt = sf_f ^ of_f;
    case (sel)
      C_ALWAYS: return 1'b1;
      C_LE:     return lt | zf_f;
      C_L:      return lt;
      C_E:      return zf_f;
      C_NE:     return !zf_f;
      C_GE:     return !lt;
      C_G:      return !lt && !zf_f;
      default:  return 1'b0;
    endcase
  endfunction

  // Computes one result and advances the shadow flags
  function automatic out_item_t execute_predict(in_item_t it);
    out_item_t r;
    logic [1:0] st;
    word_t va, vb, vc, ve;
    logic taken, ok, ovf;
    logic [3:0] de;
    st = it.stage_status;
    va = word_t'(it.value_a);
    vb = word_t'(it.value_b);
    vc = word_t'(it.const_value);
    ve = '0;
    taken = 1'b0;
    de = it.dest_e_in;
    if (st != STAT_AOK) flags_on = 1'b0;
    if (st != STAT_INS) begin
      case (it.instr_code)
        I_REGMOVE, I_JXX: begin
          taken = cond_holds(it.instr_func);
          ve = va;
        end
        I_IMMMOVE, I_DUMP: ve = vc;
        I_STORE, I_LOAD: ve = vc + vb;
        I_OPL: begin
          ok = 1'b1;
          ovf = 1'b0;
          case (it.instr_func)
            ALU_ADD: begin
              ve = vb + va;
              ovf = (va[DATA_W-1] == vb[DATA_W-1]) && (ve[DATA_W-1] != vb[DATA_W-1]);
            end
            ALU_SUB: begin
              ve = vb - va;
              ovf = (va[DATA_W-1] != vb[DATA_W-1]) && (ve[DATA_W-1] != vb[DATA_W-1]);
            end
            ALU_AND: ve = vb & va;
            ALU_XOR: ve = vb ^ va;
            default: begin
              ok = 1'b0;
              st = STAT_INS;
              ve = '0;
            end
          endcase
          if (flags_on) begin
            if (ok) of_f = ovf;
            zf_f = (ve == '0);
            sf_f = ve[DATA_W-1];
          end
        end
        I_CALL, I_PUSHL: ve = vb - word_t'(StepConst);
        I_RET, I_POPL:   ve = vb + word_t'(StepConst);
        default: ve = '0;
      endcase
    end
    // cmov not taken drops its write
    if (it.instr_code == I_REGMOVE && !taken) de = RegNone;

    if (it.mem_stage_status != STAT_AOK || it.wb_stage_status != STAT_AOK) begin
      if (flags_on) begin
        zf_f = 1'b0;
        sf_f = 1'b0;
        of_f = 1'b0;
      end
      r.out_status    = STAT_AOK;
      r.out_code      = I_NOP;
      r.cond_true     = 1'b0;
      r.exec_value    = '0;
      r.pass_value_a  = '0;
      r.dest_e_out    = RegNone;
      r.dest_m_out    = RegNone;
      r.bubble_memory = 1'b1;
    end else begin
      r.out_status    = st;
      r.out_code      = it.instr_code;
      r.cond_true     = taken;
      r.exec_value    = FIELD_W'(ve);
      r.pass_value_a  = it.value_a;
      r.dest_e_out    = de;
      r.dest_m_out    = it.dest_m_in;
      r.bubble_memory = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  in_item_t  seen_in;
  out_item_t seen_out;
  out_item_t want;

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    bubbles_seen = 0;
    taken_seen   = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      zf_f = 1'b0;
      sf_f = 1'b0;
      of_f = 1'b0;
      flags_on = 1'b1;
      exec_results_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        seen_out.out_status    = result.out_status;
        seen_out.out_code      = result.out_code;
        seen_out.cond_true     = result.cond_true;
        seen_out.exec_value    = result.exec_value;
        seen_out.pass_value_a  = result.pass_value_a;
        seen_out.dest_e_out    = result.dest_e_out;
        seen_out.dest_m_out    = result.dest_m_out;
        seen_out.bubble_memory = result.bubble_memory;
        results_seen++;
        if (exec_results_q.size() == 0) begin
          $error("result item arrived with no instruction outstanding");
          mismatches++;
        end else begin
          want = exec_results_q.pop_front();
          if (want.bubble_memory) bubbles_seen++;
          if (want.cond_true) taken_seen++;
          check_field("out_status", want.out_status, seen_out.out_status);
          check_field("out_code", want.out_code, seen_out.out_code);
          check_field("cond_true", want.cond_true, seen_out.cond_true);
          check_field("exec_value", want.exec_value, seen_out.exec_value);
          check_field("pass_value_a", want.pass_value_a, seen_out.pass_value_a);
          check_field("dest_e_out", want.dest_e_out, seen_out.dest_e_out);
          check_field("dest_m_out", want.dest_m_out, seen_out.dest_m_out);
          check_field("bubble_memory", want.bubble_memory, seen_out.bubble_memory);
        end
      end
      if (instr.valid && instr.ready) begin
        seen_in.stage_status     = instr.stage_status;
        seen_in.instr_code       = instr.instr_code;
        seen_in.instr_func       = instr.instr_func;
        seen_in.const_value      = instr.const_value;
        seen_in.value_a          = instr.value_a;
        seen_in.value_b          = instr.value_b;
        seen_in.dest_e_in        = instr.dest_e_in;
        seen_in.dest_m_in        = instr.dest_m_in;
        seen_in.mem_stage_status = instr.mem_stage_status;
        seen_in.wb_stage_status  = instr.wb_stage_status;
        exec_results_q.push_back(execute_predict(seen_in));
      end
    end
    pending = exec_results_q.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top for the Y86 execute stage: stimulus, idling, pressure and verdict.
`timescale 1ns / 100ps

module tb_top;
  import y86ex_pkg::*;

  // Run limits and pacing
  localparam int CycleLimit   = 200000;
  localparam int IdlePercent  = 38;
  localparam int RxHoldCycles = 60;
  localparam int DrainCycles  = 8;

  // Icodes past dump and the top of the 4-bit function field
  localparam logic [3:0] IcodeSpareLo = 4'd13;
  localparam logic [3:0] FieldMax     = 4'hF;
  localparam logic [3:0] AluBadFn     = 4'(ALU_XOR + 1);
  localparam logic [3:0] CondBadSel   = 4'(C_G + 1);

  logic clk;
  logic rst;

  y86ex_in_if  instr_ch ();
  y86ex_out_if result_ch ();

  int mismatches, pending, results_seen, bubbles_seen, taken_seen;
  int sent;
  int cycles;

  // Pacing controls shared by the sender and receiver processes
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;

  y86_execute_stage_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  y86ex_exec_checker exec_check (
    .clk          (clk),
    .rst          (rst),
    .instr        (instr_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .bubbles_seen (bubbles_seen),
    .taken_seen   (taken_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: no correct run gets anywhere near this
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("[y86_execute_stage_unit] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when asked for.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
      end
      result_ch.ready <= rx_calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Mostly benign operand values, with the 32-bit corners well represented
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'($urandom_range(8));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic in_item_t instr_item(logic [1:0] st, logic [3:0] code, logic [3:0] fn,
                                          logic [31:0] c, logic [31:0] a, logic [31:0] b,
                                          logic [1:0] ms = STAT_AOK,
                                          logic [1:0] ws = STAT_AOK);
    in_item_t it;
    it.stage_status     = st;
    it.instr_code       = code;
    it.instr_func       = fn;
    it.const_value      = c;
    it.value_a          = a;
    it.value_b          = b;
    it.dest_e_in        = 4'($urandom_range(RegNone - 1));
    it.dest_m_in        = 4'($urandom_range(FieldMax));
    it.mem_stage_status = ms;
    it.wb_stage_status  = ws;
    return it;
  endfunction

  // Random instruction. Mostly well-formed ALU ops, jumps and cmovs so the
  // flags actually get exercised; a slice of bad functions and spare icodes.
  // Pipeline exceptions are kept rare since a bubble clears the flags.
  function automatic in_item_t random_instr(bit allow_exc);
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = instr_item(STAT_AOK, I_NOP, ALU_ADD, pick_word(), pick_word(), pick_word());
    if (sel < 22)      it.instr_code = I_OPL;
    else if (sel < 38) it.instr_code = I_JXX;
    else if (sel < 52) it.instr_code = I_REGMOVE;
    else if (sel < 56) it.instr_code = 4'($urandom_range(IcodeSpareLo, FieldMax));
    else               it.instr_code = 4'($urandom_range(I_HALT, I_DUMP));

    case (it.instr_code)
      I_OPL: begin
        if ($urandom_range(99) < 90) it.instr_func = 4'($urandom_range(ALU_ADD, ALU_XOR));
        else it.instr_func = 4'($urandom_range(AluBadFn, FieldMax));
        if ($urandom_range(9) == 0) it.value_a = it.value_b;   // forces a zero result on sub/xor
      end
      I_JXX, I_REGMOVE: begin
        if ($urandom_range(99) < 88) it.instr_func = 4'($urandom_range(C_ALWAYS, C_G));
        else it.instr_func = 4'($urandom_range(CondBadSel, FieldMax));
      end
      default: it.instr_func = 4'($urandom_range(FieldMax));
    endcase

    if ($urandom_range(99) < 5) it.mem_stage_status = 2'($urandom_range(STAT_HLT, STAT_INS));
    if ($urandom_range(99) < 5) it.wb_stage_status = 2'($urandom_range(STAT_HLT, STAT_INS));
    if (allow_exc) it.stage_status = 2'($urandom_range(STAT_AOK, STAT_INS));
    return it;
  endfunction

  // Random idle cycles ahead of the next item, valid low throughout
  task automatic tx_gap();
    if (!tx_calm && $urandom_range(99) < IdlePercent) begin
      repeat ($urandom_range(1, 3)) begin
        instr_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Present one item and hold it until the stage takes it
  task automatic send_instr(input in_item_t it);
    tx_gap();
    instr_ch.valid            <= 1'b1;
    instr_ch.stage_status     <= it.stage_status;
    instr_ch.instr_code       <= it.instr_code;
    instr_ch.instr_func       <= it.instr_func;
    instr_ch.const_value      <= it.const_value;
    instr_ch.value_a          <= it.value_a;
    instr_ch.value_b          <= it.value_b;
    instr_ch.dest_e_in        <= it.dest_e_in;
    instr_ch.dest_m_in        <= it.dest_m_in;
    instr_ch.mem_stage_status <= it.mem_stage_status;
    instr_ch.wb_stage_status  <= it.wb_stage_status;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    sent        = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_hold_req = 1'b0;
    rst         = 1'b1;
    instr_ch.valid            = 1'b0;
    instr_ch.stage_status     = STAT_AOK;
    instr_ch.instr_code       = I_NOP;
    instr_ch.instr_func       = ALU_ADD;
    instr_ch.const_value      = '0;
    instr_ch.value_a          = '0;
    instr_ch.value_b          = '0;
    instr_ch.dest_e_in        = RegNone;
    instr_ch.dest_m_in        = RegNone;
    instr_ch.mem_stage_status = STAT_AOK;
    instr_ch.wb_stage_status  = STAT_AOK;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- Directed: flags and conditions while flag updates are live ---
    // add overflow: SF=1 OF=1, so "less" is false
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_ADD, '0, 32'h0000_0001, 32'h7FFF_FFFF));
    send_instr(instr_item(STAT_AOK, I_JXX, C_L, 32'h100, 32'h200, '0));
    send_instr(instr_item(STAT_AOK, I_REGMOVE, C_LE, '0, 32'hDEAD_BEEF, '0));  // cmov not taken
    send_instr(instr_item(STAT_AOK, I_JXX, C_GE, '0, 32'h300, '0));
    // equal subtract: ZF
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_SUB, '0, 32'd5, 32'd5));
    send_instr(instr_item(STAT_AOK, I_JXX, C_E, '0, 32'h400, '0));
    send_instr(instr_item(STAT_AOK, I_REGMOVE, C_NE, '0, 32'h1234_5678, '0));
    send_instr(instr_item(STAT_AOK, I_JXX, C_G, '0, 32'h500, '0));
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_AND, '0, 32'h8000_0000, 32'hFFFF_FFFF));
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_XOR, '0, 32'h5A5A_5A5A, 32'hA5A5_A5A5));
    // subtract overflow from most negative
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_SUB, '0, 32'h0000_0001, 32'h8000_0000));
    send_instr(instr_item(STAT_AOK, I_REGMOVE, C_ALWAYS, '0, 32'hFFFF_FFFF, '0));
    // bad ALU function: status becomes bad instruction, ZF set, OF kept
    send_instr(instr_item(STAT_AOK, I_OPL, AluBadFn, '0, 32'h7, 32'h9));
    send_instr(instr_item(STAT_AOK, I_JXX, CondBadSel, '0, 32'h600, '0));    // undefined selector
    // address and stack arithmetic, with wraparound
    send_instr(instr_item(STAT_AOK, I_IMMMOVE, '0, 32'h8000_0000, '0, '0));
    send_instr(instr_item(STAT_AOK, I_STORE, '0, 32'h7FFF_FFFF, 32'h11, 32'h0000_0001));
    send_instr(instr_item(STAT_AOK, I_LOAD, '0, 32'hFFFF_FFFC, '0, '0));
    send_instr(instr_item(STAT_AOK, I_CALL, '0, 32'h40, '0, 32'h0000_0000));
    send_instr(instr_item(STAT_AOK, I_RET, '0, '0, '0, 32'hFFFF_FFFC));
    send_instr(instr_item(STAT_AOK, I_PUSHL, '0, '0, 32'hCAFE_F00D, 32'h8000_0000));
    send_instr(instr_item(STAT_AOK, I_POPL, '0, '0, '0, 32'h7FFF_FFFE));
    send_instr(instr_item(STAT_AOK, I_DUMP, '0, 32'h1234_5678, '0, '0));
    send_instr(instr_item(STAT_AOK, IcodeSpareLo, FieldMax, 32'hFFFF_FFFF, '0, 32'h1));
    // exception further down the pipe: bubble, flags cleared
    send_instr(instr_item(STAT_AOK, I_OPL, ALU_ADD, '0, 32'h1, 32'h2, STAT_ADR, STAT_AOK));
    send_instr(instr_item(STAT_AOK, I_JXX, C_E, '0, 32'h700, '0, STAT_AOK, STAT_INS));

    // --- Random with ordinary idling on both sides ---
    repeat (300) send_instr(random_instr(1'b0));

    // --- Long stretch with no idling anywhere ---
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (150) send_instr(random_instr(1'b0));
    rx_calm = 1'b0;

    // --- Receiver holds off while the sender keeps offering: input stalls ---
    rx_hold_req = 1'b1;
    repeat (40) send_instr(random_instr(1'b0));
    tx_calm = 1'b0;

    // --- Sender pauses until everything is back ---
    drain();
    repeat (300) send_instr(random_instr(1'b0));
    drain();

    // --- Exception status in this stage: freezes flag updates for good ---
    send_instr(instr_item(STAT_HLT, I_OPL, ALU_ADD, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_instr(instr_item(STAT_AOK, I_JXX, C_E, '0, 32'h800, '0));
    send_instr(instr_item(STAT_INS, I_REGMOVE, C_ALWAYS, '0, 32'h55, '0));
    send_instr(instr_item(STAT_ADR, I_LOAD, '0, 32'h10, '0, 32'h20));
    send_instr(instr_item(STAT_INS, I_OPL, ALU_SUB, '0, 32'h3, 32'h3));
    repeat (60) send_instr(random_instr(1'b1));

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d instructions; checked %0d results, %0d bubbled, %0d with condition set.",
             sent, results_seen, bubbles_seen, taken_seen);
    $display("Covered ALU, address, stack and condition paths, back-pressure, and flag freeze.");
    if (mismatches == 0 && pending == 0) begin
      $display("[y86_execute_stage_unit] OK");
    end else begin
      $display("[y86_execute_stage_unit] ERROR");
    end
    $finish;
  end

endmodule
